FILE: sv/pse_pkg.sv
// shared types, token and status codes for the postfix stack evaluator
// no dependencies; imported by pse_stack, pse_alu and postfix_stack_evaluator
`default_nettype none

package pse_pkg;

   localparam int DATA_W          = 32;
   localparam int ACT_W           = 3;
   localparam int STAT_W          = 2;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STAT_W-1:0] ST_DIVZERO   = 2'd3;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   // dividend is |a| shifted up by the fraction width
   localparam int FRAC_W = 16;
   localparam int QUO_W  = DATA_W + FRAC_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_ALU_WAIT,
      S_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_DFIN
   } alu_state_type;

   typedef struct packed {
      logic                     start;
      logic [ACT_W-1:0]         op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

`default_nettype wire

FILE: sv/pse_stack.sv
// operand stack memory: one write port, two registered read ports
// depends on pse_pkg
`default_nettype none

module pse_stack #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [$clog2(STACK_DEPTH)-1:0]     wr_addr,
   input  wire logic signed [pse_pkg::DATA_W-1:0]  wr_data,
   input  wire logic                               rd_en,
   input  wire logic [$clog2(STACK_DEPTH)-1:0]     rd_a_addr,
   input  wire logic [$clog2(STACK_DEPTH)-1:0]     rd_b_addr,
   output logic signed [pse_pkg::DATA_W-1:0]       rd_a_data,
   output logic signed [pse_pkg::DATA_W-1:0]       rd_b_data
);
   import pse_pkg::*;

   logic signed [DATA_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_data <= mem[rd_a_addr];
         rd_b_data <= mem[rd_b_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/pse_alu.sv
// shared arithmetic unit: saturating add/sub, multiply, restoring divide
// depends on pse_pkg
`default_nettype none

module pse_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pse_pkg::alu_req_type  alu_req,
   output pse_pkg::alu_rsp_type       alu_rsp
);
   import pse_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   alu_state_type            state_ff, state_in;
   logic                     done_ff, done_in;
   logic signed [DATA_W-1:0] result_ff, result_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [DATA_W-1:0]        div_ff, div_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic signed [DATA_W:0]   sum;
   logic [DATA_W-1:0]        a_abs, b_abs;
   logic signed [QUO_W-1:0]  mul_q;
   logic [DATA_W:0]          rem_sh, rem_sub;
   logic                     rem_ge;

   always_comb begin
      a_abs   = alu_req.a[DATA_W-1] ? (~alu_req.a + 1'b1) : alu_req.a;
      b_abs   = alu_req.b[DATA_W-1] ? (~alu_req.b + 1'b1) : alu_req.b;
      if (alu_req.op == ACT_SUB) begin
         sum = {alu_req.a[DATA_W-1], alu_req.a} - {alu_req.b[DATA_W-1], alu_req.b};
      end else begin
         sum = {alu_req.a[DATA_W-1], alu_req.a} + {alu_req.b[DATA_W-1], alu_req.b};
      end
      mul_q   = prod_ff[2*DATA_W-1:FRAC_W];
      rem_sh  = {rem_ff, quo_ff[QUO_W-1]};
      rem_ge  = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start && alu_req.op == ACT_MUL) begin
               state_in = A_MUL;
            end else if (alu_req.start && alu_req.op == ACT_DIV) begin
               state_in = A_DIV;
            end
         end
         A_MUL: begin
            state_in = A_IDLE;
         end
         A_DIV: begin
            if (cnt_ff == '0) begin
               state_in = A_DFIN;
            end
         end
         A_DFIN: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      done_in   = 1'b0;
      result_in = result_ff;
      prod_in   = prod_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               prod_in = alu_req.a * alu_req.b;
               quo_in  = {a_abs, {FRAC_W{1'b0}}};
               rem_in  = '0;
               div_in  = b_abs;
               neg_in  = alu_req.a[DATA_W-1] ^ alu_req.b[DATA_W-1];
               cnt_in  = CNT_W'(QUO_W - 1);
               if (alu_req.op == ACT_ADD || alu_req.op == ACT_SUB) begin
                  done_in = 1'b1;
                  if (sum[DATA_W] != sum[DATA_W-1]) begin
                     result_in = sum[DATA_W] ? Q_MIN : Q_MAX;
                  end else begin
                     result_in = sum[DATA_W-1:0];
                  end
               end
            end
         end
         A_MUL: begin
            done_in = 1'b1;
            // floor shift already done by taking the upper bits
            if (mul_q > QUO_W'(Q_MAX)) begin
               result_in = Q_MAX;
            end else if (mul_q < QUO_W'(Q_MIN)) begin
               result_in = Q_MIN;
            end else begin
               result_in = mul_q[DATA_W-1:0];
            end
         end
         A_DIV: begin
            rem_in = rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], rem_ge};
            cnt_in = cnt_ff - 1'b1;
         end
         A_DFIN: begin
            done_in = 1'b1;
            if (neg_ff) begin
               if (quo_ff > QUO_W'(33'h0_8000_0000)) begin
                  result_in = Q_MIN;
               end else begin
                  result_in = ~quo_ff[DATA_W-1:0] + 1'b1;
               end
            end else begin
               if (quo_ff > QUO_W'(33'h0_7FFF_FFFF)) begin
                  result_in = Q_MAX;
               end else begin
                  result_in = quo_ff[DATA_W-1:0];
               end
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;

endmodule

`default_nettype wire

FILE: sv/postfix_stack_evaluator.sv
// postfix evaluator top level: token sequencer, stack pointer, error latch, result register
// each token is captured, then decoded; arithmetic tokens then wait on the arithmetic unit (48-step divider)
// a token marked last then moves to the emit state, which loads the result register when the output is not stalled
// throughput: one token at a time, bounded by the shared arithmetic unit
// reset (synchronous, active high) empties the stack and clears the latched error
`default_nettype none

module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pse_pkg::ACT_W-1:0]          req_action,
   input  wire logic signed [pse_pkg::DATA_W-1:0]  req_operand,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [pse_pkg::DATA_W-1:0]       rsp_result_value,
   output logic [pse_pkg::STAT_W-1:0]              rsp_status
);
   import pse_pkg::*;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   seq_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [STAT_W-1:0]        err_ff, err_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic [ACT_W-1:0]         act_ff;
   logic signed [DATA_W-1:0] opnd_ff;
   logic                     last_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;

   logic                     req_xfer;
   logic                     emit_ok;
   logic                     is_op;
   logic                     go_alu;
   logic [CNT_W-1:0]         cnt_m1, cnt_m2;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic signed [DATA_W-1:0] rd_a_data, rd_b_data;

   alu_req_type              alu_req;
   alu_rsp_type              alu_rsp;

   pse_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (req_xfer),
      .rd_a_addr (cnt_m2[IDX_W-1:0]),
      .rd_b_addr (cnt_m1[IDX_W-1:0]),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   pse_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign emit_ok   = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1    = count_ff - 1'b1;
   assign cnt_m2    = count_ff - CNT_W'(2);
   assign is_op     = (act_ff == ACT_ADD) || (act_ff == ACT_SUB) ||
                      (act_ff == ACT_MUL) || (act_ff == ACT_DIV);
   assign go_alu    = (state_ff == S_DECODE) && (err_ff == ST_OK) && is_op &&
                      (count_ff >= CNT_W'(2)) &&
                      !((act_ff == ACT_DIV) && (rd_b_data == '0));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (go_alu) begin
               state_in = S_ALU_WAIT;
            end else begin
               state_in = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_ALU_WAIT: begin
            if (alu_rsp.done) begin
               state_in = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = opnd_ff;
      alu_req.start = go_alu;
      alu_req.op    = act_ff;
      alu_req.a     = rd_a_data;
      alu_req.b     = rd_b_data;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            count_in = count_ff;
         end
         S_DECODE: begin
            // ignored tokens leave the old top in place
            top_in = rd_b_data;
            if (err_ff == ST_OK) begin
               if (act_ff == ACT_PUSH) begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     top_in   = opnd_ff;
                  end
               end else if (is_op) begin
                  if (count_ff < CNT_W'(2)) begin
                     err_in = ST_UNDERFLOW;
                  end else if ((act_ff == ACT_DIV) && (rd_b_data == '0)) begin
                     err_in = ST_DIVZERO;
                  end
               end
            end
         end
         S_ALU_WAIT: begin
            wr_addr = cnt_m2[IDX_W-1:0];
            wr_data = alu_rsp.result;
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               count_in = cnt_m1;
               top_in   = alu_rsp.result;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
                  rsp_value_in  = '0;
               end else if (count_ff == '0) begin
                  rsp_status_in = ST_UNDERFLOW;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_value_in  = top_ff;
               end
               count_in = '0;
               err_in   = ST_OK;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (req_xfer) begin
         act_ff  <= req_action;
         opnd_ff <= req_operand;
         last_ff <= req_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_result_value == '0))
      else $error("error result transfer carries a non-zero value");

   a_alu_done_wait: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == S_ALU_WAIT)
      else $error("arithmetic unit finished outside its wait state");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_ok) |=> (count_ff == '0 && err_ff == ST_OK))
      else $error("stack or error not cleared after result");

   a_err_freezes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE && err_ff != ST_OK) |=> $stable(count_ff))
      else $error("token changed the stack after an error");

endmodule

`default_nettype wire
